// ===== rtl/astcwb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ASTC weight bit count package
// Shared types, register indexes and quantization tables.
// ----------------------------------------------------------------------------
package astcwb_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 4;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FOOTPRINT_WIDTH  = 2'd0,
    CFG_FOOTPRINT_HEIGHT = 2'd1,
    CFG_FOOTPRINT_DEPTH  = 2'd2,
    CFG_UNUSED           = 2'd3
  } cfg_idx_e;

  localparam logic [3:0] RstFootprintWidth = 4'd4;
  localparam logic [3:0] RstFootprintHeight = 4'd4;
  localparam logic [2:0] RstFootprintDepth = 3'd1;

  localparam logic [8:0] ModeVoidMask = 9'h1ff;
  localparam logic [8:0] ModeVoidCode = 9'h1fc;
  localparam logic [3:0] ModeLowMask = 4'hf;
  localparam logic [10:0] Res2dMask = 11'h1c3;
  localparam logic [10:0] Res2dCode = 11'h1c0;
  localparam logic [10:0] Res3dMask = 11'h1e3;
  localparam logic [10:0] Res3dCode = 11'h1e0;

  localparam logic [11:0] MaxWeights = 12'd64;
  localparam logic [9:0] MinWeightBits = 10'd24;
  localparam logic [9:0] MaxWeightBits = 10'd96;

  // Reciprocals for exact floor division of small values by 5 and by 3.
  localparam logic [7:0] RecipFive = 8'd205;   // x/5 = (x*205) >> 10, x <= 516
  localparam logic [7:0] RecipThree = 8'd171;  // x/3 = (x*171) >> 9,  x <= 450

  // Quantization tables, bit/entry i is range code i.
  localparam logic [7:0] LoTrits = 8'b0100_1000;
  localparam logic [7:0] HiTrits = 8'b0100_1000;
  localparam logic [7:0] LoQuints = 8'b0010_0000;
  localparam logic [7:0] HiQuints = 8'b0010_0100;
  localparam logic [7:0][2:0] LoBits = {3'd3, 3'd1, 3'd0, 3'd2, 3'd0, 3'd1, 3'd0, 3'd0};
  localparam logic [7:0][2:0] HiBits = {3'd5, 3'd3, 3'd2, 3'd4, 3'd2, 3'd1, 3'd0, 3'd0};

  typedef struct packed {
    logic [3:0] width;
    logic [3:0] height;
    logic [2:0] depth;
  } footprint_t;

  typedef struct packed {
    logic [3:0] grid_w;
    logic [3:0] grid_h;
    logic [2:0] grid_d;
    logic       dual;
    logic       prec;
    logic [2:0] quant;
    logic       bad;
  } mode_dec_t;

endpackage
`default_nettype wire

// ===== rtl/astcwb_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ASTC weight bit count channels
// Valid/ready channels for block modes, counts and register writes.
// ----------------------------------------------------------------------------
interface astcwb_mode_if;
  logic        valid;
  logic        ready;
  logic [15:0] block_mode;
  modport source (output valid, output block_mode, input ready);
  modport sink (input valid, input block_mode, output ready);
endinterface

interface astcwb_count_if;
  logic       valid;
  logic       ready;
  logic [6:0] weight_bit_count;
  modport source (output valid, output weight_bit_count, input ready);
  modport sink (input valid, input weight_bit_count, output ready);
endinterface

interface astcwb_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [3:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/astc_weight_bits_decode_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// An accepted block mode passes through four register stages before its count is on count_o.
// Throughput: one block mode per cycle while count_o.ready holds; the four register stages each hold
//   one request and move independently, so an empty stage fills under a stall.
// Reset: rst_ni clears all stage valid bits and loads footprint 4x4x1.
// Register writes are always ready and take effect at the next cycle.
// ----------------------------------------------------------------------------
// ASTC weight bit count decoder
// Decodes the 11-bit block mode against the configured footprint and returns
// the number of bits taken by the packed weights, or zero for unusable modes.
// ----------------------------------------------------------------------------
module astc_weight_bits_decode_top
  import astcwb_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  astcwb_mode_if.sink   mode_i,
  astcwb_count_if.source count_o,
  astcwb_cfg_if.sink    cfg_i
);

  footprint_t fp_q;
  mode_dec_t  dec;
  logic       dec_valid, dec_ready;

  // Footprint registers; writes to an unused index drop.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fp_q.width <= RstFootprintWidth;
      fp_q.height <= RstFootprintHeight;
      fp_q.depth <= RstFootprintDepth;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_FOOTPRINT_WIDTH: fp_q.width <= cfg_i.data;
        CFG_FOOTPRINT_HEIGHT: fp_q.height <= cfg_i.data;
        CFG_FOOTPRINT_DEPTH: fp_q.depth <= cfg_i.data[2:0];
        default: begin
        end
      endcase
    end
  end

  // Stage 1: field decode, reserved checks and footprint compare.
  astcwb_mode_dec u_mode_dec (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mode_i.valid),
    .ready_o (mode_i.ready),
    .mode_i  (mode_i.block_mode[10:0]),
    .fp_i    (fp_q),
    .valid_o (dec_valid),
    .ready_i (dec_ready),
    .dec_o   (dec)
  );

  // Stages 2 to 4: weight count, encoding terms, sum and range check.
  astcwb_bit_count u_bit_count (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dec_valid),
    .ready_o (dec_ready),
    .dec_i   (dec),
    .valid_o (count_o.valid),
    .ready_i (count_o.ready),
    .count_o (count_o.weight_bit_count)
  );

endmodule
`default_nettype wire

// ===== rtl/astcwb_mode_dec.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ASTC block mode decode stage
// Decodes grid size, plane, precision and range fields; checks footprint.
// ----------------------------------------------------------------------------
module astcwb_mode_dec
  import astcwb_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       valid_i,
  output      logic       ready_o,
  input  wire logic [10:0] mode_i,
  input  wire footprint_t fp_i,
  output      logic       valid_o,
  input  wire logic       ready_i,
  output      mode_dec_t  dec_o
);

  logic      valid_q;
  mode_dec_t dec_q, dec_d;

  logic [1:0] b01, b23, b56, b78, b910;
  logic [2:0] depth_eff;
  logic       is_2d;
  logic [3:0] w, h;
  logic [2:0] d;
  logic       dual, prec, reserved;
  logic [1:0] rng;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    b01 = mode_i[1:0];
    b23 = mode_i[3:2];
    b56 = mode_i[6:5];
    b78 = mode_i[8:7];
    b910 = mode_i[10:9];
    prec = mode_i[9];
    dual = mode_i[10];
    depth_eff = (fp_i.depth == 3'd0) ? 3'd1 : fp_i.depth;
    is_2d = (depth_eff <= 3'd1);
    w = 4'd2;
    h = 4'd2;
    d = 3'd1;
    rng = b01;
    reserved = (mode_i[8:0] & ModeVoidMask) == ModeVoidCode
            || (mode_i[3:0] & ModeLowMask) == 4'd0;
    if (is_2d) begin
      reserved = reserved || ((mode_i & Res2dMask) == Res2dCode);
      if (b01 != 2'd0) begin
        case (b23)
          2'd0: begin w = 4'd4 + {2'b00, b78}; h = 4'd2 + {2'b00, b56}; end
          2'd1: begin w = 4'd8 + {2'b00, b78}; h = 4'd2 + {2'b00, b56}; end
          2'd2: begin w = 4'd2 + {2'b00, b56}; h = 4'd8 + {2'b00, b78}; end
          default: begin
            if (b78[1]) begin
              w = 4'd2 + {3'b000, b78[0]};
              h = 4'd6 + {2'b00, b56};
            end else begin
              w = 4'd2 + {2'b00, b56};
              h = 4'd2 + {3'b000, b78[0]};
            end
          end
        endcase
      end else begin
        rng = b23;
        case (b78)
          2'd0: begin w = 4'd12; h = 4'd2 + {2'b00, b56}; end
          2'd1: begin w = 4'd2 + {2'b00, b56}; h = 4'd12; end
          2'd2: begin
            w = 4'd6 + {2'b00, b56};
            h = 4'd6 + {2'b00, b910};
            dual = 1'b0;
            prec = 1'b0;
          end
          default: begin
            if (b56 == 2'd0) begin w = 4'd6; h = 4'd10; end
            else begin w = 4'd10; h = 4'd6; end
          end
        endcase
      end
    end else begin
      reserved = reserved || ((mode_i & Res3dMask) == Res3dCode);
      if (b01 != 2'd0) begin
        w = 4'd2 + {2'b00, b56};
        h = 4'd2 + {2'b00, b78};
        d = 3'd2 + {1'b0, b23};
      end else begin
        rng = b23;
        case (b78)
          2'd0: begin
            w = 4'd6; h = 4'd2 + {2'b00, b910}; d = 3'd2 + {1'b0, b56};
            dual = 1'b0; prec = 1'b0;
          end
          2'd1: begin
            w = 4'd2 + {2'b00, b56}; h = 4'd6; d = 3'd2 + {1'b0, b910};
            dual = 1'b0; prec = 1'b0;
          end
          2'd2: begin
            w = 4'd2 + {2'b00, b56}; h = 4'd2 + {2'b00, b910}; d = 3'd6;
            dual = 1'b0; prec = 1'b0;
          end
          default: begin
            case (b56)
              2'd0: begin w = 4'd6; h = 4'd2; d = 3'd2; end
              2'd1: begin w = 4'd2; h = 4'd6; d = 3'd2; end
              default: begin w = 4'd2; h = 4'd2; d = 3'd6; end
            endcase
          end
        endcase
      end
    end
    dec_d.grid_w = w;
    dec_d.grid_h = h;
    dec_d.grid_d = d;
    dec_d.dual = dual;
    dec_d.prec = prec;
    dec_d.quant = {rng, mode_i[4]};
    dec_d.bad = reserved || (w > fp_i.width) || (h > fp_i.height) || (d > depth_eff);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      dec_q <= dec_d;
    end
  end

  assign valid_o = valid_q;
  assign dec_o = dec_q;

endmodule
`default_nettype wire

// ===== rtl/astcwb_bit_count.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ASTC weight bit count stages
// Weight count, per-encoding bit terms, then sum and range check.
// ----------------------------------------------------------------------------
module astcwb_bit_count
  import astcwb_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      valid_i,
  output      logic      ready_o,
  input  wire mode_dec_t dec_i,
  output      logic      valid_o,
  input  wire logic      ready_i,
  output      logic [6:0] count_o
);

  // stage 2: weight count and table lookup
  logic       v2_q, rdy2;
  logic [6:0] n2_q;
  logic       bad2_q, trit2_q, quint2_q;
  logic [2:0] bits2_q;
  logic [7:0] wh;
  logic [10:0] whd;
  logic [11:0] n_full;

  // stage 3: encoding terms
  logic       v3_q, rdy3;
  logic [6:0] tri3_q;
  logic [7:0] quint3_q;
  logic [8:0] bits3_q;
  logic       bad3_q;
  logic [17:0] tri_prod;
  logic [16:0] quint_prod;
  logic [9:0]  n8p4;
  logic [8:0]  n7p2;

  // stage 4: output register
  logic       v4_q, rdy4;
  logic [6:0] count4_q;
  logic [9:0] total;

  assign rdy4 = !v4_q || ready_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign ready_o = rdy2;

  always_comb begin
    wh = {4'd0, dec_i.grid_w} * {4'd0, dec_i.grid_h};
    whd = {3'b000, wh} * {8'd0, dec_i.grid_d};
    n_full = dec_i.dual ? {whd, 1'b0} : {1'b0, whd};
  end

  always_comb begin
    n8p4 = {n2_q, 3'b000} + 10'd4;
    n7p2 = ({2'b00, n2_q} * 9'd7) + 9'd2;
    tri_prod = {8'd0, n8p4} * {10'd0, RecipFive};
    quint_prod = {8'd0, n7p2} * {9'd0, RecipThree};
  end

  assign total = {3'b000, tri3_q} + {2'b00, quint3_q} + {1'b0, bits3_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy2) begin
        v2_q <= valid_i;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (rdy4) begin
        v4_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && valid_i) begin
      n2_q <= n_full[6:0];
      bad2_q <= dec_i.bad || (n_full > MaxWeights);
      trit2_q <= dec_i.prec ? HiTrits[dec_i.quant] : LoTrits[dec_i.quant];
      quint2_q <= dec_i.prec ? HiQuints[dec_i.quant] : LoQuints[dec_i.quant];
      bits2_q <= dec_i.prec ? HiBits[dec_i.quant] : LoBits[dec_i.quant];
    end
    if (rdy3 && v2_q) begin
      tri3_q <= trit2_q ? tri_prod[16:10] : 7'd0;
      quint3_q <= quint2_q ? quint_prod[16:9] : 8'd0;
      bits3_q <= {2'b00, n2_q} * {6'd0, bits2_q};
      bad3_q <= bad2_q;
    end
    if (rdy4 && v3_q) begin
      count4_q <= (bad3_q || total < MinWeightBits || total > MaxWeightBits)
                  ? 7'd0 : total[6:0];
    end
  end

  assign valid_o = v4_q;
  assign count_o = count4_q;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q |-> (count4_q == 7'd0 || (count4_q >= 7'd24 && count4_q <= 7'd96)))
    else $error("weight bit count outside legal range");
  a_weights_fit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !bad2_q) |-> (n2_q != 7'd0 && n2_q <= 7'd64))
    else $error("accepted weight count out of range");
  a_terms_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !bad3_q) |-> (tri3_q <= 7'd103 && quint3_q <= 8'd150 && bits3_q <= 9'd320))
    else $error("encoding term exceeds bound");
`endif

endmodule
`default_nettype wire
